FILE: design/apr_pkg.sv
// ----------------------------------------------------------------------------
// apr_pkg: shared types and constants of the parameter ramp engine
// Command codes, curve codes and the records passed between the front end,
// the command queue and the ramp back end.
// ----------------------------------------------------------------------------
package apr_pkg;

    localparam int LEN_W  = 24;   // ramp length field
    localparam int VAL_W  = 32;   // Q16.16 values
    localparam int TV_W   = 48;   // time field on the port
    localparam int FRAC_W = 32;   // interpolation factor, Q0.32

    typedef logic [2:0] t_op;

    // request codes as they arrive on the port
    localparam t_op REQ_TICK   = 3'd0;
    localparam t_op REQ_APPLY  = 3'd1;
    localparam t_op REQ_APPEND = 3'd2;
    localparam t_op REQ_SET    = 3'd3;
    localparam t_op REQ_CLEAR  = 3'd4;

    // internal operation codes after classification
    localparam t_op OP_TICK   = 3'd0;
    localparam t_op OP_APPLY  = 3'd1;
    localparam t_op OP_APPEND = 3'd2;
    localparam t_op OP_SET    = 3'd3;
    localparam t_op OP_CLEAR  = 3'd4;
    localparam t_op OP_NOP    = 3'd5;

    localparam logic [1:0] CURVE_LIN = 2'd0;
    localparam logic [1:0] CURVE_IN  = 2'd1;
    localparam logic [1:0] CURVE_OUT = 2'd2;

    typedef struct packed {
        t_op                     op;
        logic [TV_W-1:0]         time_value;
        logic                    time_is_absolute;
        logic [LEN_W-1:0]        ramp_length;
        logic signed [VAL_W-1:0] value_begin;
        logic signed [VAL_W-1:0] value_end;
        logic                    use_held_begin;
        logic [1:0]              curve;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_q_push;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

endpackage

FILE: design/apr_ifs.sv
// ----------------------------------------------------------------------------
// apr_ifs: request and result channel interfaces
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface apr_req_if;
    logic                valid;
    logic                ready;
    logic [2:0]          req_type;
    logic [47:0]         time_value;
    logic                time_is_absolute;
    logic [23:0]         ramp_length;
    logic signed [31:0]  value_begin;
    logic signed [31:0]  value_end;
    logic                use_held_begin;
    logic [1:0]          curve;

    modport source (output valid, req_type, time_value, time_is_absolute, ramp_length,
                    value_begin, value_end, use_held_begin, curve, input ready);
    modport sink   (input valid, req_type, time_value, time_is_absolute, ramp_length,
                    value_begin, value_end, use_held_begin, curve, output ready);
endinterface

interface apr_res_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  sample_value;
    logic                varying;
    logic                status;
    logic [3:0]          pending_events;

    modport source (output valid, sample_value, varying, status, pending_events,
                    input ready);
    modport sink   (input valid, sample_value, varying, status, pending_events,
                    output ready);
endinterface

FILE: design/audio_parameter_ramp_engine_top.sv
// ----------------------------------------------------------------------------
// audio_parameter_ramp_engine_top: per-sample parameter ramp automation
// Keeps an ordered table of ramp events and produces one Q16.16 parameter
// value (or status) per command transaction.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake           payload
//  i_req     in   valid/ready         req_type, time_value, time_is_absolute,
//                                     ramp_length, value_begin, value_end,
//                                     use_held_begin, curve
//  o_res     out  valid/ready         sample_value, varying, status,
//                                     pending_events
//  i_cfg_*   in   write enable only   initial_value (loads held value)
//
//  Set/clear/no-op and a dropped ramp are handled in the idle state alone,
//  a queued apply/append in the idle and push states.
//  A tick starts in the idle state, then scans one slot per cycle. For an
//  active ramp it waits on the serial fraction divider, then steps through
//  the square, curve, multiply and rounding states.
//  Reset (synchronous, active low) empties the table and queue, zeroes sample
//  time and the held value; no clearing pass is needed.
//  A 2-entry queue keeps taking requests while a result waits on o_res; the
//  back end starts a command only once the result register is free.
//
module audio_parameter_ramp_engine_top #(
    parameter int EVENT_SLOTS = 8,
    parameter int TIME_BITS   = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    apr_req_if.sink     i_req,
    apr_res_if.source   o_res,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data
);

    apr_pkg::t_q_push q_push;
    apr_pkg::t_q_head q_head;
    logic             q_full;
    logic             q_pop;

    // front end: intake and request classification
    apr_front u_front (
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_push   (q_push)
    );

    // decoupling queue
    apr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_full  (q_full),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    // back end: event table, tick scan, interpolation
    apr_back #(
        .EVENT_SLOTS (EVENT_SLOTS),
        .TIME_BITS   (TIME_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (q_head),
        .o_pop         (q_pop),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_res         (o_res)
    );

    // the back end only takes a command that is really there
    a_pop_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_head.valid)
        else $error("queue popped while empty");

    // a command starts only with the result register free
    a_pop_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !o_res.valid)
        else $error("command started over a pending result");

    // a dropped ramp reports a full table
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status) |-> (o_res.pending_events == 4'(EVENT_SLOTS)))
        else $error("table-full status with room left");

endmodule

FILE: design/apr_front.sv
// ----------------------------------------------------------------------------
// apr_front: request intake and classification
// Takes request transactions while the queue has room and maps request codes
// onto internal operations; unused codes become a no-op.
// ----------------------------------------------------------------------------
module apr_front (
    apr_req_if.sink          i_req,
    input  logic             i_q_full,
    output apr_pkg::t_q_push o_push
);

    assign i_req.ready = !i_q_full;

    always_comb begin
        o_push.push                 = i_req.valid && !i_q_full;
        o_push.cmd.time_value       = i_req.time_value;
        o_push.cmd.time_is_absolute = i_req.time_is_absolute;
        o_push.cmd.ramp_length      = i_req.ramp_length;
        o_push.cmd.value_begin      = i_req.value_begin;
        o_push.cmd.value_end        = i_req.value_end;
        o_push.cmd.use_held_begin   = i_req.use_held_begin;
        o_push.cmd.curve            = i_req.curve;
        unique case (i_req.req_type)
            apr_pkg::REQ_TICK:   o_push.cmd.op = apr_pkg::OP_TICK;
            apr_pkg::REQ_APPLY:  o_push.cmd.op = apr_pkg::OP_APPLY;
            apr_pkg::REQ_APPEND: o_push.cmd.op = apr_pkg::OP_APPEND;
            apr_pkg::REQ_SET:    o_push.cmd.op = apr_pkg::OP_SET;
            apr_pkg::REQ_CLEAR:  o_push.cmd.op = apr_pkg::OP_CLEAR;
            default:             o_push.cmd.op = apr_pkg::OP_NOP;
        endcase
    end

endmodule

FILE: design/apr_queue.sv
// ----------------------------------------------------------------------------
// apr_queue: two-entry command queue
// Decouples request intake from the ramp back end.
// ----------------------------------------------------------------------------
module apr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  apr_pkg::t_q_push i_push,
    output logic             o_full,
    output apr_pkg::t_q_head o_head,
    input  logic             i_pop
);

    apr_pkg::t_cmd r_mem [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;

    // held full during reset so no transaction is taken and lost
    assign o_full       = (r_cnt == 2'd2) || !i_rst_n;
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push.push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push.push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.cmd;
        end
    end

endmodule

FILE: design/apr_frac_div.sv
// ----------------------------------------------------------------------------
// apr_frac_div: serial fraction divider
// floor(num * 2^32 / den) for num < den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module apr_frac_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [apr_pkg::LEN_W-1:0]    i_num,
    input  logic [apr_pkg::LEN_W-1:0]    i_den,
    output logic                         o_done,
    output logic [apr_pkg::FRAC_W-1:0]   o_quot
);

    localparam int CW = $clog2(apr_pkg::FRAC_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CW-1:0]               r_cnt;
    logic [apr_pkg::LEN_W-1:0]   r_rem;
    logic [apr_pkg::LEN_W-1:0]   r_den;
    logic [apr_pkg::FRAC_W-1:0]  r_q;
    logic [apr_pkg::LEN_W:0]     sh;
    logic                        ge;

    assign sh     = {r_rem, 1'b0};
    assign ge     = (sh >= {1'b0, r_den});
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(apr_pkg::FRAC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? apr_pkg::LEN_W'(sh - {1'b0, r_den}) : apr_pkg::LEN_W'(sh);
            r_q   <= {r_q[apr_pkg::FRAC_W-2:0], ge};
        end
    end

endmodule

FILE: design/apr_back.sv
// ----------------------------------------------------------------------------
// apr_back: ramp event table and command sequencer
// Runs one queued command at a time: table scan and interpolation for a tick,
// cut/cancel and queueing for ramps, and the held value.
// ----------------------------------------------------------------------------
module apr_back #(
    parameter int EVENT_SLOTS = 8,
    parameter int TIME_BITS   = 48
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  apr_pkg::t_q_head i_head,
    output logic             o_pop,
    input  logic             i_cfg_wr_en,
    input  logic [31:0]      i_cfg_wr_data,
    apr_res_if.source        o_res
);

    localparam int CNT_W = $clog2(EVENT_SLOTS + 1);
    localparam int IDX_W = $clog2(EVENT_SLOTS);
    localparam int LW    = apr_pkg::LEN_W;
    localparam int FW    = apr_pkg::FRAC_W;
    localparam logic [TIME_BITS-1:0] T_MAX = '1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SQ    = 3'd3;
    localparam logic [2:0] S_CURVE = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_ROUND = 3'd6;
    localparam logic [2:0] S_PUSH  = 3'd7;

    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? T_MAX : s[TIME_BITS-1:0];
    endfunction

    // control
    logic [2:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic [TIME_BITS-1:0]  r_time, n_time;
    logic signed [31:0]    r_held, n_held;
    logic                  r_out_valid, n_out_valid;

    // event table
    logic [TIME_BITS-1:0]  r_start [EVENT_SLOTS], n_start [EVENT_SLOTS];
    logic [TIME_BITS-1:0]  r_stop  [EVENT_SLOTS], n_stop  [EVENT_SLOTS];
    logic [TIME_BITS-1:0]  r_cut   [EVENT_SLOTS], n_cut   [EVENT_SLOTS];
    logic                  r_cut_set [EVENT_SLOTS], n_cut_set [EVENT_SLOTS];
    logic signed [31:0]    r_from  [EVENT_SLOTS], n_from  [EVENT_SLOTS];
    logic signed [31:0]    r_to    [EVENT_SLOTS], n_to    [EVENT_SLOTS];
    logic                  r_copy  [EVENT_SLOTS], n_copy  [EVENT_SLOTS];
    logic                  r_cancel [EVENT_SLOTS], n_cancel [EVENT_SLOTS];
    logic [1:0]            r_curv  [EVENT_SLOTS], n_curv  [EVENT_SLOTS];

    // command working set
    apr_pkg::t_cmd         r_cmd, n_cmd;
    logic [TIME_BITS-1:0]  r_new_start, n_new_start;
    logic signed [31:0]    r_refv, n_refv;
    logic                  r_do_cut, n_do_cut;

    // interpolation datapath
    logic [FW-1:0]         r_f, n_f;
    logic [FW-1:0]         r_sq, n_sq;
    logic [FW:0]           r_fac, n_fac;
    logic [32:0]           r_absd, n_absd;
    logic                  r_neg, n_neg;
    logic signed [31:0]    r_ifrom, n_ifrom;
    logic signed [31:0]    r_ito, n_ito;
    logic [1:0]            r_icurve, n_icurve;
    logic [65:0]           r_mag, n_mag;

    // result register
    logic signed [31:0]    r_out_value, n_out_value;
    logic                  r_out_varying, n_out_varying;
    logic                  r_out_status, n_out_status;
    logic [3:0]            r_out_pend, n_out_pend;

    // divider link
    logic                  div_start;
    logic [LW-1:0]         div_num;
    logic [LW-1:0]         div_den;
    logic                  div_done;
    logic [FW-1:0]         div_q;

    // scratch
    logic                  emit;
    logic                  emit_vary;
    logic                  emit_status;
    logic                  drop;
    logic                  skip;
    logic                  canc;
    logic [IDX_W-1:0]      i;
    logic [IDX_W-1:0]      last;
    logic [IDX_W-1:0]      w;
    logic [TIME_BITS-1:0]  tv_in;
    logic [TIME_BITS-1:0]  ref_t;
    logic [63:0]           sq_full;
    logic signed [32:0]    diff;
    logic [32:0]           m;
    logic signed [33:0]    res;

    apr_frac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign o_res.valid          = r_out_valid;
    assign o_res.sample_value   = r_out_value;
    assign o_res.varying        = r_out_varying;
    assign o_res.status         = r_out_status;
    assign o_res.pending_events = r_out_pend;

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_time        = r_time;
        n_held        = r_held;
        n_out_valid   = r_out_valid;
        n_start       = r_start;
        n_stop        = r_stop;
        n_cut         = r_cut;
        n_cut_set     = r_cut_set;
        n_from        = r_from;
        n_to          = r_to;
        n_copy        = r_copy;
        n_cancel      = r_cancel;
        n_curv        = r_curv;
        n_cmd         = r_cmd;
        n_new_start   = r_new_start;
        n_refv        = r_refv;
        n_do_cut      = r_do_cut;
        n_f           = r_f;
        n_sq          = r_sq;
        n_fac         = r_fac;
        n_absd        = r_absd;
        n_neg         = r_neg;
        n_ifrom       = r_ifrom;
        n_ito         = r_ito;
        n_icurve      = r_icurve;
        n_mag         = r_mag;
        n_out_value   = r_out_value;
        n_out_varying = r_out_varying;
        n_out_status  = r_out_status;
        n_out_pend    = r_out_pend;
        o_pop         = 1'b0;
        div_start     = 1'b0;
        div_num       = '0;
        div_den       = '0;
        emit          = 1'b0;
        emit_vary     = 1'b0;
        emit_status   = 1'b0;
        drop          = 1'b0;
        skip          = 1'b0;
        canc          = 1'b0;
        i             = r_idx[IDX_W-1:0];
        last          = IDX_W'(r_count - CNT_W'(1));
        w             = r_count[IDX_W-1:0];
        tv_in         = TIME_BITS'(i_head.cmd.time_value);
        ref_t         = r_time;
        sq_full       = 64'(r_f) * 64'(r_f);
        diff          = 33'(r_ito) - 33'(r_ifrom);
        m             = 33'((r_mag + 66'h0_8000_0000) >> 32);
        res           = r_neg ? (34'(r_ifrom) - $signed({1'b0, m}))
                              : (34'(r_ifrom) + $signed({1'b0, m}));

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid && !r_out_valid) begin
                    o_pop = 1'b1;
                    n_cmd = i_head.cmd;
                    unique case (i_head.cmd.op)
                        apr_pkg::OP_TICK: begin
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                        apr_pkg::OP_APPLY, apr_pkg::OP_APPEND: begin
                            if (r_count >= CNT_W'(EVENT_SLOTS)) begin
                                emit        = 1'b1;
                                emit_status = 1'b1;
                            end else if (i_head.cmd.op == apr_pkg::OP_APPLY) begin
                                n_new_start = i_head.cmd.time_is_absolute ? tv_in
                                                                          : sat_add(r_time, tv_in);
                                n_refv   = r_held;
                                n_do_cut = 1'b1;
                                n_state  = S_PUSH;
                            end else begin
                                n_refv = r_held;
                                if (r_count != '0) begin
                                    ref_t  = r_stop[last];
                                    n_refv = r_to[last];
                                end
                                n_new_start = i_head.cmd.time_is_absolute ? tv_in
                                                                          : sat_add(ref_t, tv_in);
                                n_do_cut = 1'b0;
                                n_state  = S_PUSH;
                            end
                        end
                        apr_pkg::OP_SET: begin
                            n_count = '0;
                            n_held  = i_head.cmd.value_begin;
                            emit    = 1'b1;
                        end
                        apr_pkg::OP_CLEAR: begin
                            n_count = '0;
                            emit    = 1'b1;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end

            S_PUSH: begin
                if (r_do_cut) begin
                    for (int k = 0; k < EVENT_SLOTS; k++) begin
                        if (CNT_W'(k) < r_count) begin
                            if (r_start[k] >= r_new_start) begin
                                n_cancel[k] = 1'b1;
                            end else if (r_stop[k] >= r_new_start) begin
                                if (!r_cut_set[k] || (r_new_start < r_cut[k])) begin
                                    n_cut[k] = r_new_start;
                                end
                                n_cut_set[k] = 1'b1;
                            end
                        end
                    end
                end
                n_start[w]   = r_new_start;
                n_stop[w]    = sat_add(r_new_start, TIME_BITS'(r_cmd.ramp_length));
                n_cut[w]     = '0;
                n_cut_set[w] = 1'b0;
                n_from[w]    = r_cmd.use_held_begin ? r_refv : r_cmd.value_begin;
                n_to[w]      = r_cmd.value_end;
                n_copy[w]    = r_cmd.use_held_begin;
                n_cancel[w]  = 1'b0;
                n_curv[w]    = r_cmd.curve;
                n_count      = r_count + CNT_W'(1);
                emit         = 1'b1;
                n_state      = S_IDLE;
            end

            S_SCAN: begin
                if (r_idx == r_count) begin
                    n_time  = sat_add(r_time, TIME_BITS'(1));
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    canc = r_cancel[i];
                    if ((r_stop[i] <= r_time) || canc) begin
                        if ((r_count == CNT_W'(1)) && !canc) begin
                            n_held = r_to[i];
                        end
                        drop = 1'b1;
                    end else if (r_start[i] <= r_time) begin
                        if (r_cut_set[i] && (r_cut[i] < r_time)) begin
                            drop = 1'b1;
                        end else begin
                            skip = r_cut_set[i] && (r_cut[i] == r_time);
                            if (skip) begin
                                n_cancel[i] = 1'b1;
                            end
                            if (r_copy[i]) begin
                                n_from[i] = r_held;
                                n_copy[i] = 1'b0;
                            end
                            if (!skip) begin
                                n_ifrom   = r_copy[i] ? r_held : r_from[i];
                                n_ito     = r_to[i];
                                n_icurve  = r_curv[i];
                                div_num   = LW'(r_time - r_start[i]);
                                div_den   = LW'(r_stop[i] - r_start[i]);
                                div_start = 1'b1;
                                n_state   = S_DIV;
                            end else begin
                                n_idx = r_idx + CNT_W'(1);
                            end
                        end
                    end else begin
                        n_idx = r_idx + CNT_W'(1);
                    end
                    if (drop) begin
                        // close the gap: every slot from here on takes its successor
                        for (int k = 0; k < EVENT_SLOTS - 1; k++) begin
                            if (CNT_W'(k) >= r_idx) begin
                                n_start[k]   = r_start[k+1];
                                n_stop[k]    = r_stop[k+1];
                                n_cut[k]     = r_cut[k+1];
                                n_cut_set[k] = r_cut_set[k+1];
                                n_from[k]    = r_from[k+1];
                                n_to[k]      = r_to[k+1];
                                n_copy[k]    = r_copy[k+1];
                                n_cancel[k]  = r_cancel[k+1];
                                n_curv[k]    = r_curv[k+1];
                            end
                        end
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end

            S_DIV: begin
                if (div_done) begin
                    n_f     = div_q;
                    n_state = S_SQ;
                end
            end

            S_SQ: begin
                n_sq    = sq_full[63:32];
                n_neg   = diff < 0;
                n_absd  = (diff < 0) ? 33'(-diff) : 33'(diff);
                n_state = S_CURVE;
            end

            S_CURVE: begin
                case (r_icurve)
                    apr_pkg::CURVE_IN:  n_fac = {1'b0, r_sq};
                    apr_pkg::CURVE_OUT: n_fac = {r_f, 1'b0} - {1'b0, r_sq};
                    default:            n_fac = {1'b0, r_f};
                endcase
                n_state = S_MUL;
            end

            S_MUL: begin
                n_mag   = 66'(r_absd) * 66'(r_fac);
                n_state = S_ROUND;
            end

            S_ROUND: begin
                n_held    = res[31:0];
                n_time    = sat_add(r_time, TIME_BITS'(1));
                emit      = 1'b1;
                emit_vary = 1'b1;
                n_state   = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase

        if (i_cfg_wr_en) begin
            n_held = i_cfg_wr_data;
        end

        if (emit) begin
            n_out_valid   = 1'b1;
            n_out_value   = n_held;
            n_out_varying = emit_vary;
            n_out_status  = emit_status;
            n_out_pend    = 4'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_time      <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_time      <= n_time;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start       <= n_start;
        r_stop        <= n_stop;
        r_cut         <= n_cut;
        r_cut_set     <= n_cut_set;
        r_from        <= n_from;
        r_to          <= n_to;
        r_copy        <= n_copy;
        r_cancel      <= n_cancel;
        r_curv        <= n_curv;
        r_cmd         <= n_cmd;
        r_new_start   <= n_new_start;
        r_refv        <= n_refv;
        r_do_cut      <= n_do_cut;
        r_f           <= n_f;
        r_sq          <= n_sq;
        r_fac         <= n_fac;
        r_absd        <= n_absd;
        r_neg         <= n_neg;
        r_ifrom       <= n_ifrom;
        r_ito         <= n_ito;
        r_icurve      <= n_icurve;
        r_mag         <= n_mag;
        r_out_value   <= n_out_value;
        r_out_varying <= n_out_varying;
        r_out_status  <= n_out_status;
        r_out_pend    <= n_out_pend;
    end

endmodule

FILE: tb/sv/audio_parameter_ramp_engine_top_tb.sv
// ----------------------------------------------------------------------------
// audio_parameter_ramp_engine_top_tb: self-checking bench for the ramp engine
// Drives command transactions from a queue, predicts every result with an
// in-bench model of the event table and compares results field by field.
// ----------------------------------------------------------------------------
module audio_parameter_ramp_engine_top_tb;

    localparam int              SLOTS        = 8;
    localparam bit [63:0]       TIME_MAX     = 64'h0000_FFFF_FFFF_FFFF;
    localparam int              CYCLE_LIMIT  = 600000;
    localparam int              DRAIN_CYCLES = 120;    // outlasts the longest tick
    localparam logic [1:0]      CURVE_SPARE  = 2'd3;   // decodes as linear
    localparam apr_pkg::t_op    REQ_SPARE_5  = 3'd5;
    localparam apr_pkg::t_op    REQ_SPARE_6  = 3'd6;
    localparam apr_pkg::t_op    REQ_SPARE_7  = 3'd7;

    typedef struct {
        apr_pkg::t_op req;
        bit [47:0]    tv;
        bit           absolute;
        bit [23:0]    len;
        bit [31:0]    vb;
        bit [31:0]    ve;
        bit           use_held;
        bit [1:0]     cv;
    } t_ramp_cmd;

    typedef struct {
        bit [31:0] value;
        bit        varying;
        bit        status;
        bit [3:0]  pending;
    } t_ramp_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [31:0] i_cfg_wr_data;

    apr_req_if req_ch ();
    apr_res_if res_ch ();

    audio_parameter_ramp_engine_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .o_res         (res_ch),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        i_clk = 1'b0; #6;
        i_clk = 1'b1; #6;
    end

    t_ramp_cmd    pending_cmds[$];
    t_ramp_result expected_results[$];
    int           errors;
    int           results_seen;
    int           cycles;
    bit           quiet;          // no idling on either side
    int           holdoff;
    bit           holdoff_done;
    longint       est_time;       // sample time as seen by the generator

    // ------------------------------------------------------------------
    // Predictor: shadow event table
    // ------------------------------------------------------------------
    longint    held;
    bit [63:0] stime;
    int        ev_n;
    bit [63:0] ev_start [SLOTS];
    bit [63:0] ev_stop  [SLOTS];
    bit [63:0] ev_cut   [SLOTS];
    bit        ev_cutv  [SLOTS];
    longint    ev_from  [SLOTS];
    longint    ev_to    [SLOTS];
    bit        ev_copy  [SLOTS];
    bit        ev_cancel[SLOTS];
    bit [1:0]  ev_curve [SLOTS];

    function automatic bit [63:0] time_sat_add(bit [63:0] a, bit [63:0] b);
        bit [63:0] s;
        s = a + b;
        if (s < a || s > TIME_MAX) s = TIME_MAX;
        return s;
    endfunction

    function automatic void drop_slot(int i);
        for (int k = i; k + 1 < ev_n; k++) begin
            ev_start[k]  = ev_start[k+1];
            ev_stop[k]   = ev_stop[k+1];
            ev_cut[k]    = ev_cut[k+1];
            ev_cutv[k]   = ev_cutv[k+1];
            ev_from[k]   = ev_from[k+1];
            ev_to[k]     = ev_to[k+1];
            ev_copy[k]   = ev_copy[k+1];
            ev_cancel[k] = ev_cancel[k+1];
            ev_curve[k]  = ev_curve[k+1];
        end
        if (ev_n > 0) ev_n--;
    endfunction

    // 64-bit wrapping arithmetic kept on purpose: it is what the block computes
    function automatic longint ramp_value(int i, bit [63:0] t);
        bit [95:0] q;
        bit [63:0] d, p, f, sq, fac, absd, mag, m;
        longint    a, diff;
        d  = ev_stop[i] - ev_start[i];
        p  = t - ev_start[i];
        q  = {p, 32'h0} / {32'h0, d};
        f  = q[63:0];
        sq = (f * f) >> 32;
        fac = f;
        if (ev_curve[i] == apr_pkg::CURVE_IN) fac = sq;
        else if (ev_curve[i] == apr_pkg::CURVE_OUT) fac = 2 * f - sq;
        a    = ev_from[i];
        diff = ev_to[i] - a;
        absd = (diff < 0) ? -diff : diff;
        mag  = absd * fac;
        m    = (mag + 64'h8000_0000) >> 32;
        return (diff < 0) ? a - longint'(m) : a + longint'(m);
    endfunction

    function automatic bit tick_step();
        int i;
        bit skip;
        i = 0;
        while (i < ev_n) begin
            if (ev_stop[i] <= stime || ev_cancel[i]) begin
                if (ev_n == 1 && !ev_cancel[i]) held = ev_to[i];
                drop_slot(i);
                continue;
            end
            if (ev_start[i] <= stime) begin
                if (ev_cutv[i] && ev_cut[i] < stime) begin
                    drop_slot(i);
                    continue;
                end
                skip = ev_cutv[i] && ev_cut[i] == stime;
                if (skip) ev_cancel[i] = 1'b1;
                if (ev_copy[i]) begin
                    ev_from[i] = held;
                    ev_copy[i] = 1'b0;
                end
                if (!skip) begin
                    held = ramp_value(i, stime);
                    return 1'b1;
                end
            end
            i++;
        end
        return 1'b0;
    endfunction

    function automatic void cut_table(bit [63:0] at);
        for (int i = 0; i < ev_n; i++) begin
            if (ev_start[i] >= at) ev_cancel[i] = 1'b1;
            else if (ev_stop[i] >= at) begin
                if (!ev_cutv[i] || at < ev_cut[i]) ev_cut[i] = at;
                ev_cutv[i] = 1'b1;
            end
        end
    endfunction

    function automatic void add_event(bit [63:0] start, bit [23:0] len, longint from,
                                      longint to, bit copy, bit [1:0] cv);
        ev_start[ev_n]  = start;
        ev_stop[ev_n]   = time_sat_add(start, {40'h0, len});
        ev_cut[ev_n]    = '0;
        ev_cutv[ev_n]   = 1'b0;
        ev_from[ev_n]   = from;
        ev_to[ev_n]     = to;
        ev_copy[ev_n]   = copy;
        ev_cancel[ev_n] = 1'b0;
        ev_curve[ev_n]  = cv;
        ev_n++;
    endfunction

    function automatic t_ramp_result predict_ramp(t_ramp_cmd c);
        t_ramp_result r;
        bit [63:0]    start, ref_t;
        longint       ref_v, vb, ve;
        vb = longint'($signed(c.vb));
        ve = longint'($signed(c.ve));
        r.varying = 1'b0;
        r.status  = 1'b0;
        case (c.req)
            apr_pkg::REQ_TICK: begin
                r.varying = tick_step();
                stime = time_sat_add(stime, 64'd1);
            end
            apr_pkg::REQ_APPLY, apr_pkg::REQ_APPEND: begin
                if (ev_n >= SLOTS) r.status = 1'b1;
                else if (c.req == apr_pkg::REQ_APPLY) begin
                    start = c.absolute ? {16'h0, c.tv} : time_sat_add(stime, {16'h0, c.tv});
                    cut_table(start);
                    add_event(start, c.len, c.use_held ? held : vb, ve, c.use_held, c.cv);
                end else begin
                    ref_t = stime;
                    ref_v = held;
                    if (ev_n > 0) begin
                        ref_t = ev_stop[ev_n-1];
                        ref_v = ev_to[ev_n-1];
                    end
                    start = c.absolute ? {16'h0, c.tv} : time_sat_add(ref_t, {16'h0, c.tv});
                    add_event(start, c.len, c.use_held ? ref_v : vb, ve, c.use_held, c.cv);
                end
            end
            apr_pkg::REQ_SET: begin
                ev_n = 0;
                held = vb;
            end
            apr_pkg::REQ_CLEAR: ev_n = 0;
            default: ;
        endcase
        r.value   = held[31:0];
        r.pending = ev_n[3:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_ramp_cmd mk_cmd(apr_pkg::t_op req, bit [47:0] tv, bit absolute,
                                         bit [23:0] len, bit [31:0] vb, bit [31:0] ve,
                                         bit use_held, bit [1:0] cv);
        t_ramp_cmd c;
        c.req = req; c.tv = tv; c.absolute = absolute; c.len = len;
        c.vb = vb; c.ve = ve; c.use_held = use_held; c.cv = cv;
        if (req == apr_pkg::REQ_TICK) est_time++;
        return c;
    endfunction

    task automatic enqueue_cmd(t_ramp_cmd c);
        pending_cmds = {pending_cmds, c};
    endtask

    // Mostly short ramps near the current sample time, then enough ticks to
    // play them; a small share of commands carry fully random fields.
    task automatic queue_random(int count);
        int        pick;
        bit [47:0] tv;
        bit [23:0] len;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 24));
            tv   = 48'($urandom_range(0, 12));
            if (pick < 50)
                enqueue_cmd(mk_cmd(apr_pkg::REQ_TICK, 48'($urandom), 1'($urandom),
                    len, $urandom, $urandom, 1'($urandom), 2'($urandom)));
            else if (pick < 68) begin
                if ($urandom_range(0, 1)) tv = 48'(est_time) + tv - 48'(4);
                enqueue_cmd(mk_cmd(apr_pkg::REQ_APPLY, tv, 1'($urandom_range(0, 1) &&
                    est_time > 4), len, $urandom, $urandom, 1'($urandom),
                    2'($urandom_range(0, 3))));
            end else if (pick < 82)
                enqueue_cmd(mk_cmd(apr_pkg::REQ_APPEND, tv, 1'b0, len, $urandom,
                    $urandom, 1'($urandom), 2'($urandom_range(0, 3))));
            else if (pick < 86)
                enqueue_cmd(mk_cmd(apr_pkg::REQ_SET, tv, 1'b0, len, $urandom,
                    $urandom, 1'b0, apr_pkg::CURVE_LIN));
            else if (pick < 89)
                enqueue_cmd(mk_cmd(apr_pkg::REQ_CLEAR, tv, 1'b0, len, $urandom,
                    $urandom, 1'b0, apr_pkg::CURVE_LIN));
            else
                enqueue_cmd(mk_cmd(3'($urandom_range(0, 7)),
                    {16'($urandom), 32'($urandom)}, 1'($urandom), 24'($urandom),
                    $urandom, $urandom, 1'($urandom), 2'($urandom)));
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_cmds.size() != 0 || req_ch.valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // config writes land only while nothing is in flight
    task automatic write_initial(bit [31:0] v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        held = longint'($signed(v));
    endtask

    task automatic report_mismatch(string field, longint got, longint want);
        errors++;
        $display("mismatch on result %0d: %s got %0h want %0h", results_seen, field, got, want);
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued commands, predicts on each accepted transaction
    // ------------------------------------------------------------------
    int        send_gap;
    t_ramp_cmd cur_cmd;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid            <= 1'b0;
            req_ch.req_type         <= apr_pkg::REQ_TICK;
            req_ch.time_value       <= '0;
            req_ch.time_is_absolute <= 1'b0;
            req_ch.ramp_length      <= '0;
            req_ch.value_begin      <= '0;
            req_ch.value_end        <= '0;
            req_ch.use_held_begin   <= 1'b0;
            req_ch.curve            <= apr_pkg::CURVE_LIN;
            send_gap = 0;
        end else begin
            if (req_ch.valid && req_ch.ready)
                expected_results = {expected_results, predict_ramp(cur_cmd)};
            if (!req_ch.valid || req_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end else if (pending_cmds.size() == 0) begin
                    req_ch.valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 6) == 0) begin
                    send_gap = $urandom_range(0, 8);     // idle burst before the next command
                    req_ch.valid <= 1'b0;
                end else begin
                    cur_cmd = pending_cmds.pop_front();
                    req_ch.valid            <= 1'b1;
                    req_ch.req_type         <= cur_cmd.req;
                    req_ch.time_value       <= cur_cmd.tv;
                    req_ch.time_is_absolute <= cur_cmd.absolute;
                    req_ch.ramp_length      <= cur_cmd.len;
                    req_ch.value_begin      <= cur_cmd.vb;
                    req_ch.value_end        <= cur_cmd.ve;
                    req_ch.use_held_begin   <= cur_cmd.use_held;
                    req_ch.curve            <= cur_cmd.cv;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, compares each result transaction
    // ------------------------------------------------------------------
    int           recv_stall;
    t_ramp_result want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", res_ch.sample_value, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (res_ch.sample_value !== want.value)
                        report_mismatch("sample_value", res_ch.sample_value, want.value);
                    if (res_ch.varying !== want.varying)
                        report_mismatch("varying", res_ch.varying, want.varying);
                    if (res_ch.status !== want.status)
                        report_mismatch("status", res_ch.status, want.status);
                    if (res_ch.pending_events !== want.pending)
                        report_mismatch("pending_events", res_ch.pending_events,
                                        want.pending);
                end
            end
            if (recv_stall > 0) recv_stall--;
            else if (!quiet && $urandom_range(0, 7) == 0) recv_stall = $urandom_range(1, 9);
            res_ch.ready <= (recv_stall == 0) && (holdoff == 0);
        end
    end

    // One long receiver hold-off so the input queue fills and back-pressures.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            holdoff      <= 0;
            holdoff_done <= 1'b0;
        end else if (holdoff > 0) begin
            holdoff <= holdoff - 1;
        end else if (!holdoff_done && results_seen >= 150) begin
            holdoff      <= 400;
            holdoff_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("audio_parameter_ramp_engine_top_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        quiet = 1'b0; est_time = 0;
        held = 0; stime = '0; ev_n = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: largest initial value, then each command and corner
        write_initial(32'h7FFF_FFFF);
        enqueue_cmd(mk_cmd(apr_pkg::REQ_TICK, '0, 1'b0, '0, '0, '0, 1'b0,
                           apr_pkg::CURVE_LIN));
        enqueue_cmd(mk_cmd(apr_pkg::REQ_SET, '0, 1'b0, '0, 32'h8000_0000, '0, 1'b0,
                           apr_pkg::CURVE_LIN));
        enqueue_cmd(mk_cmd(apr_pkg::REQ_APPLY, 48'd2, 1'b1, 24'd4, 32'h0, 32'h7FFF_FFFF,
                           1'b0, apr_pkg::CURVE_LIN));
        // zero length ramp: pruned at first tick at or after its start
        enqueue_cmd(mk_cmd(apr_pkg::REQ_APPEND, '0, 1'b0, 24'd0, '0, 32'd5, 1'b0,
                           apr_pkg::CURVE_LIN));
        enqueue_cmd(mk_cmd(apr_pkg::REQ_APPEND, 48'd1, 1'b0, 24'd3, '0, 32'h8000_0000,
                           1'b1, apr_pkg::CURVE_IN));
        enqueue_cmd(mk_cmd(apr_pkg::REQ_APPEND, '0, 1'b0, 24'd5, 32'h1234_5678,
                           32'hFFFF_0000, 1'b0, CURVE_SPARE));
        for (int k = 0; k < 4; k++)
            enqueue_cmd(mk_cmd(apr_pkg::REQ_APPEND, 48'd2, 1'b0, 24'd3, $urandom,
                               $urandom, 1'b0, apr_pkg::CURVE_OUT));
        // table is full now: both are dropped with status set
        enqueue_cmd(mk_cmd(apr_pkg::REQ_APPLY, '0, 1'b0, 24'd2, '0, '0, 1'b0,
                           apr_pkg::CURVE_LIN));
        enqueue_cmd(mk_cmd(apr_pkg::REQ_APPEND, '0, 1'b0, 24'd2, '0, '0, 1'b0,
                           apr_pkg::CURVE_LIN));
        for (int k = 0; k < 5; k++)
            enqueue_cmd(mk_cmd(apr_pkg::REQ_TICK, '0, 1'b0, '0, '0, '0, 1'b0,
                               apr_pkg::CURVE_LIN));
        // apply while the table is still full: dropped with status set
        enqueue_cmd(mk_cmd(apr_pkg::REQ_APPLY, 48'd1, 1'b0, 24'd6, 32'h0001_0000,
                           32'hFFFE_0000, 1'b1, apr_pkg::CURVE_LIN));
        enqueue_cmd(mk_cmd(REQ_SPARE_5, '1, 1'b1, '1, '1, '1, 1'b1, CURVE_SPARE));
        enqueue_cmd(mk_cmd(REQ_SPARE_6, '0, 1'b0, '0, '0, '0, 1'b0, apr_pkg::CURVE_LIN));
        enqueue_cmd(mk_cmd(REQ_SPARE_7, '0, 1'b0, '0, '0, '0, 1'b0, apr_pkg::CURVE_LIN));
        enqueue_cmd(mk_cmd(apr_pkg::REQ_CLEAR, '0, 1'b0, '0, '0, '0, 1'b0,
                           apr_pkg::CURVE_LIN));
        // time saturation, absolute and relative
        enqueue_cmd(mk_cmd(apr_pkg::REQ_APPLY, '1, 1'b1, '1, 32'h8000_0000,
                           32'h7FFF_FFFF, 1'b0, apr_pkg::CURVE_OUT));
        enqueue_cmd(mk_cmd(apr_pkg::REQ_APPLY, '1, 1'b0, '1, '0, '0, 1'b0,
                           apr_pkg::CURVE_IN));
        enqueue_cmd(mk_cmd(apr_pkg::REQ_TICK, '0, 1'b0, '0, '0, '0, 1'b0,
                           apr_pkg::CURVE_LIN));
        wait_idle();

        write_initial(32'h8000_0000);
        enqueue_cmd(mk_cmd(apr_pkg::REQ_CLEAR, '0, 1'b0, '0, '0, '0, 1'b0,
                           apr_pkg::CURVE_LIN));
        queue_random(200);
        wait_idle();

        write_initial(32'h0000_0000);
        enqueue_cmd(mk_cmd(apr_pkg::REQ_CLEAR, '0, 1'b0, '0, '0, '0, 1'b0,
                           apr_pkg::CURVE_LIN));
        queue_random(200);
        wait_idle();

        // final stretch runs back to back
        write_initial($urandom);
        quiet = 1'b1;
        queue_random(200);
        wait_idle();

        if (errors == 0)
            $display("audio_parameter_ramp_engine_top_tb: clean");
        else
            $display("audio_parameter_ramp_engine_top_tb: errors");
        $finish;
    end

endmodule
